[design/pidfd_pkg.sv]
// Package for the filtered-derivative PID controller: widths, constants and control types.
`default_nettype none

package pidfd_pkg;

	// Data path widths.
	localparam int DW = 32;
	localparam int SPW = 20;
	localparam int IDXW = 3;
	localparam int FRAC = 16;

	// Multiplier operands are magnitudes of values up to 33 bits signed.
	localparam int MW = DW + 1;
	localparam int PW = 2 * MW;

	// Derivative filter time constant tau, Q16.16 seconds.
	localparam int TAU_Q16 = 1311;
	localparam int TAU2 = 2 * TAU_Q16;

	// Filter denominator 2*tau + T stays below 2^26 for tau up to 2^24.
	localparam int DENW = 26;
	localparam int DIV_STEPS = DW;
	localparam int CNTW = $clog2(DIV_STEPS);

	// Milliseconds per second, used by the update gate.
	localparam int MS_PER_S = 1000;

	// Register reset values.
	localparam int KP_RESET = 65536;
	localparam int SP_RESET = 655;

	// Configuration register indexes.
	typedef enum logic [IDXW-1:0] {
		REG_KP   = 3'd0,
		REG_KI   = 3'd1,
		REG_KD   = 3'd2,
		REG_SP   = 3'd3,
		REG_OMIN = 3'd4,
		REG_OMAX = 3'd5,
		REG_IMIN = 3'd6,
		REG_IMAX = 3'd7
	} cfg_idx_e;

	// Product issued to the shared multiplier; also tags the result register.
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_KTH,
		MUL_FILT,
		MUL_PROP,
		MUL_INT,
		MUL_DER
	} mul_sel_e;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic     ld_in;
		logic     ld_gate;
		logic     ld_esum;
		mul_sel_e mul;
		logic     ld_isum;
		logic     ld_num;
		logic     clamp_i;
		logic     ld_div;
		logic     ld_ovf;
		logic     div_step;
		logic     ld_d;
		logic     ld_ysum;
		logic     clamp_y;
		logic     ld_out;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic held;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[design/pidfd_if.sv]
// Channel interfaces of the PID controller: sample input, result output and register writes.
`default_nettype none

interface pidfd_in_if import pidfd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] target_value;
	logic signed [DW-1:0] measured_value;
	logic [DW-1:0]        now_ms;

	modport source (output valid, output target_value, output measured_value,
		output now_ms, input ready);
	modport sink (input valid, input target_value, input measured_value,
		input now_ms, output ready);
endinterface

interface pidfd_out_if import pidfd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] drive;
	logic                 updated;

	modport source (output valid, output drive, output updated, input ready);
	modport sink (input valid, input drive, input updated, output ready);
endinterface

interface pidfd_cfg_if import pidfd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IDXW-1:0] index;
	logic [DW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/pidfd_ctrl.sv]
// Sequencer of the PID controller: steps one item through gate, products, divide and clamps.
`default_nettype none

module pidfd_ctrl import pidfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_GATE   = 17'h00002,
		S_KTH    = 17'h00004,
		S_FILT   = 17'h00008,
		S_PROP   = 17'h00010,
		S_INT    = 17'h00020,
		S_DER    = 17'h00040,
		S_WAIT   = 17'h00080,
		S_ISUM   = 17'h00100,
		S_NUM    = 17'h00200,
		S_DLOAD  = 17'h00400,
		S_DCHK   = 17'h00800,
		S_DRUN   = 17'h01000,
		S_DEND   = 17'h02000,
		S_YSUM   = 17'h04000,
		S_YCLP   = 17'h08000,
		S_OUT    = 17'h10000
	} state_t;

	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(DIV_STEPS - 1);

	state_t          state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		cmd = '0;
		state_d = state_q;
		cnt_d = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d = S_GATE;
				end
			end
			S_GATE: begin
				cmd.ld_gate = 1'b1;
				state_d = sts.held ? S_OUT : S_KTH;
			end
			S_KTH: begin
				cmd.mul = MUL_KTH;
				cmd.ld_esum = 1'b1;
				state_d = S_FILT;
			end
			S_FILT: begin
				cmd.mul = MUL_FILT;
				state_d = S_PROP;
			end
			S_PROP: begin
				cmd.mul = MUL_PROP;
				state_d = S_INT;
			end
			S_INT: begin
				cmd.mul = MUL_INT;
				state_d = S_DER;
			end
			S_DER: begin
				cmd.mul = MUL_DER;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				state_d = S_ISUM;
			end
			S_ISUM: begin
				cmd.ld_isum = 1'b1;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.ld_num = 1'b1;
				cmd.clamp_i = 1'b1;
				state_d = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.ld_div = 1'b1;
				state_d = S_DCHK;
			end
			S_DCHK: begin
				cmd.ld_ovf = 1'b1;
				cnt_d = '0;
				state_d = S_DRUN;
			end
			S_DRUN: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + CNTW'(1);
				if (cnt_q == DIV_LAST) begin
					state_d = S_DEND;
				end
			end
			S_DEND: begin
				cmd.ld_d = 1'b1;
				state_d = S_YSUM;
			end
			S_YSUM: begin
				cmd.ld_ysum = 1'b1;
				state_d = S_YCLP;
			end
			S_YCLP: begin
				cmd.clamp_y = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and step counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	// An accepted item always goes to the gate check next.
	a_accept_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_GATE))
		else $error("accepted item did not enter the gate check");

	// A held sample skips all arithmetic.
	a_held_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GATE && sts.held) |=> (state_q == S_OUT))
		else $error("held sample did not go straight to the output");

	// The divider runs exactly its number of steps.
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRUN && cnt_q == DIV_LAST) |=> (state_q == S_DEND))
		else $error("divider did not finish after its last step");

endmodule

`default_nettype wire

[design/pidfd_dp.sv]
// Datapath of the PID controller: registers, shared multiplier, divider and clamps.
`default_nettype none

module pidfd_dp import pidfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic signed [DW-1:0] target_value,
	input  logic signed [DW-1:0] measured_value,
	input  logic [DW-1:0]        now_ms,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDXW-1:0]      cfg_index,
	input  logic [DW-1:0]        cfg_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic signed [DW-1:0] drive,
	output logic                 updated
);

	localparam int SW = DW + 2;
	localparam int MXW = MW + 1;
	localparam int CW = DENW + 1;
	localparam int RW = DENW + 1;
	localparam int DVW = DW + FRAC;
	localparam int SHW = $clog2(FRAC + 2);
	localparam logic signed [DW-1:0] MAXPOS = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINNEG = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] TOP_BIT = {1'b1, {(DW-1){1'b0}}};

	// Saturate a wide signed sum to the data width.
	function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
		if (v[SW-1:DW-1] == {(SW-DW+1){v[SW-1]}}) begin
			return v[DW-1:0];
		end else if (v[SW-1]) begin
			return MINNEG;
		end else begin
			return MAXPOS;
		end
	endfunction

	// Apply a sign to a magnitude limited to 2^31, saturating the positive side.
	function automatic logic signed [DW-1:0] lim_sign(input logic [DW-1:0] m,
		input logic over, input logic neg);
		logic [DW-1:0] lm;
		lm = over ? TOP_BIT : m;
		if (neg) begin
			return DW'(0) - lm;
		end else if (lm[DW-1]) begin
			return MAXPOS;
		end else begin
			return lm;
		end
	endfunction

	// Upper clamp first, then the lower one.
	function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] x,
		input logic signed [DW-1:0] hi, input logic signed [DW-1:0] lo);
		if (x > hi) begin
			return hi;
		end else if (x < lo) begin
			return lo;
		end else begin
			return x;
		end
	endfunction

	function automatic logic [MW-1:0] absv(input logic signed [MXW-1:0] v);
		return v[MXW-1] ? MW'(-v) : MW'(v);
	endfunction

	// Configuration registers.
	logic signed [DW-1:0] kp_q, ki_q, kd_q, omin_q, omax_q, imin_q, imax_q;
	logic [SPW-1:0]       sp_q;

	// Controller state kept between items.
	logic signed [DW-1:0] iacc_q, dacc_q, lerr_q, lmeas_q, hold_q;
	logic [DW-1:0]        lupd_q;

	// Item and intermediate registers.
	logic signed [DW-1:0] tgt_q, meas_q, err_q, kth_q, p_q, a_q, b_q, iterm_q;
	logic signed [DW-1:0] integ_q, num_q, d_q, y_q;
	logic [DW-1:0]        now_q;
	logic signed [DW:0]   dm_q, esum_q;
	logic                 upd_q;

	// Divider registers.
	logic [RW-1:0]        rem_q;
	logic [DW-1:0]        quo_q;
	logic                 ovf_q;

	// Multiplier pipeline.
	logic [MW-1:0]        opa_s1, opb_s1;
	logic                 neg_s1, neg_s2;
	mul_sel_e             tag_s1, tag_s2;
	logic [PW-1:0]        prod_s2;

	// Output register.
	logic                 out_valid_q;
	logic signed [DW-1:0] drive_q;
	logic                 updated_q;

	logic [DW-1:0]        elapsed;
	logic [DVW-1:0]       el_scaled, per_scaled;
	logic signed [CW-1:0] c_val;
	logic [DENW-1:0]      den;
	logic                 den_zero;
	logic signed [MXW-1:0] opx, opy;
	logic [SHW-1:0]       rsh;
	logic [PW-1:0]        rsum, rmag;
	logic                 rover;
	logic signed [DW-1:0] rval;
	logic [DW-1:0]        num_mag;
	logic                 dneg;
	logic [DVW-1:0]       dvd;
	logic [RW-1:0]        trial;
	logic                 qbit;

	assign cfg_ready = 1'b1;
	assign res_valid = out_valid_q;
	assign drive = drive_q;
	assign updated = updated_q;

	// Update gate: hold while elapsed * 2^16 < T * 1000.
	always_comb begin
		elapsed = now_q - lupd_q;
		el_scaled = {elapsed, {FRAC{1'b0}}};
		per_scaled = DVW'(sp_q) * DVW'(MS_PER_S);
	end

	assign sts.held = (el_scaled < per_scaled);
	assign sts.out_free = !out_valid_q || res_ready;

	// Filter coefficients 2*tau - T and 2*tau + T.
	assign c_val = CW'(TAU2) - CW'(sp_q);
	assign den = DENW'(TAU2) + DENW'(sp_q);
	assign den_zero = (den == '0);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul)
			MUL_KTH: begin
				opx = MXW'(ki_q);
				opy = MXW'(sp_q);
			end
			MUL_FILT: begin
				opx = MXW'(c_val);
				opy = MXW'(dacc_q);
			end
			MUL_PROP: begin
				opx = MXW'(kp_q);
				opy = MXW'(err_q);
			end
			MUL_INT: begin
				opx = MXW'(kth_q);
				opy = MXW'(esum_q);
			end
			MUL_DER: begin
				opx = MXW'(kd_q);
				opy = MXW'(dm_q);
			end
			default: begin
				opx = '0;
				opy = '0;
			end
		endcase
	end

	// Round to nearest, ties away from zero, then limit and sign.
	always_comb begin
		case (tag_s2)
			MUL_KTH: rsh = SHW'(FRAC + 1);
			MUL_DER: rsh = SHW'(FRAC - 1);
			default: rsh = SHW'(FRAC);
		endcase
		rsum = prod_s2 + (PW'(1) << (rsh - SHW'(1)));
		rmag = rsum >> rsh;
		rover = (|rmag[PW-1:DW]) || (rmag[DW-1] && (|rmag[DW-2:0]));
		rval = lim_sign(rmag[DW-1:0], rover, neg_s2);
	end

	// Dividend |num| * 2^16 + den/2; the quotient is negative when num is positive.
	always_comb begin
		num_mag = num_q[DW-1] ? (DW'(0) - num_q) : num_q;
		dneg = !num_q[DW-1] && (|num_q);
		dvd = {num_mag, {FRAC{1'b0}}} + DVW'(den >> 1);
		trial = {rem_q[RW-2:0], quo_q[DW-1]};
		qbit = (trial >= RW'(den));
	end

	// Multiplier pipeline tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= MUL_NONE;
			tag_s2 <= MUL_NONE;
		end else begin
			tag_s1 <= cmd.mul;
			tag_s2 <= tag_s1;
		end
	end

	// Multiplier operands, product and rounded result capture.
	always_ff @(posedge clk) begin
		opa_s1 <= absv(opx);
		opb_s1 <= absv(opy);
		neg_s1 <= opx[MXW-1] ^ opy[MXW-1];
		prod_s2 <= PW'(opa_s1) * PW'(opb_s1);
		neg_s2 <= neg_s1;
		case (tag_s2)
			MUL_KTH:  kth_q <= rval;
			MUL_FILT: b_q <= rval;
			MUL_PROP: p_q <= rval;
			MUL_INT:  iterm_q <= rval;
			MUL_DER:  a_q <= rval;
			default: ;
		endcase
	end

	// Item arithmetic, divider and clamps.
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			tgt_q <= target_value;
			meas_q <= measured_value;
			now_q <= now_ms;
		end
		if (cmd.ld_gate) begin
			err_q <= sat_dw(SW'(tgt_q) - SW'(meas_q));
			dm_q <= (DW+1)'(meas_q) - (DW+1)'(lmeas_q);
			upd_q <= !sts.held;
			y_q <= hold_q;
		end
		if (cmd.ld_esum) begin
			esum_q <= (DW+1)'(err_q) + (DW+1)'(lerr_q);
		end
		if (cmd.ld_isum) begin
			integ_q <= sat_dw(SW'(iacc_q) + SW'(iterm_q));
		end
		if (cmd.ld_num) begin
			num_q <= sat_dw(SW'(a_q) + SW'(b_q));
		end
		if (cmd.clamp_i) begin
			integ_q <= clamp(integ_q, imax_q, imin_q);
		end
		if (cmd.ld_div) begin
			rem_q <= RW'(dvd[DVW-1:DW]);
			quo_q <= dvd[DW-1:0];
		end
		if (cmd.ld_ovf) begin
			ovf_q <= (rem_q >= RW'(den));
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? (trial - RW'(den)) : trial;
			quo_q <= {quo_q[DW-2:0], qbit};
		end
		if (cmd.ld_d) begin
			d_q <= den_zero ? '0 : lim_sign(quo_q,
				ovf_q || (quo_q[DW-1] && (|quo_q[DW-2:0])), dneg);
		end
		if (cmd.ld_ysum) begin
			y_q <= sat_dw(SW'(p_q) + SW'(integ_q) + SW'(d_q));
		end
		if (cmd.clamp_y) begin
			y_q <= clamp(y_q, omax_q, omin_q);
		end
		if (cmd.ld_out) begin
			drive_q <= y_q;
			updated_q <= upd_q;
		end
	end

	// Configuration, controller state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= DW'(KP_RESET);
			ki_q <= '0;
			kd_q <= '0;
			sp_q <= SPW'(SP_RESET);
			omin_q <= MINNEG;
			omax_q <= MAXPOS;
			imin_q <= MINNEG;
			imax_q <= MAXPOS;
			iacc_q <= '0;
			dacc_q <= '0;
			lerr_q <= '0;
			lmeas_q <= '0;
			hold_q <= '0;
			lupd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_e'(cfg_index))
					REG_KP:   kp_q <= cfg_data;
					REG_KI:   ki_q <= cfg_data;
					REG_KD:   kd_q <= cfg_data;
					REG_SP:   sp_q <= cfg_data[SPW-1:0];
					REG_OMIN: omin_q <= cfg_data;
					REG_OMAX: omax_q <= cfg_data;
					REG_IMIN: imin_q <= cfg_data;
					REG_IMAX: imax_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
				if (upd_q) begin
					iacc_q <= integ_q;
					dacc_q <= d_q;
					lerr_q <= err_q;
					lmeas_q <= meas_q;
					hold_q <= y_q;
					lupd_q <= now_q;
				end
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is only loaded into a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (!out_valid_q || res_ready))
		else $error("result loaded over an untaken result");

	// A held result always shows the stored output.
	a_held_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !updated_q) |-> (drive_q == hold_q))
		else $error("held result differs from the stored output");

	// A stalled result item stays valid and unchanged.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_ready) |=>
			(out_valid_q && $stable(drive_q) && $stable(updated_q)))
		else $error("stalled result item changed or was dropped");

endmodule

`default_nettype wire

[design/pid_controller_filtered_derivative_top.sv]
// Top level of the PID controller with band-limited derivative on the measurement.
//
// Channels: samp takes one item per sample (setpoint, measurement, millisecond
// tick), res returns one item per sample (drive and an updated flag), and cfg
// writes the eight gain, period and limit registers by index. All use valid
// and ready; a transfer happens on a rising edge with both high. cfg is always
// ready; it must be written only while the block is idle, which the block
// itself does not enforce. A sample inside the sample period is answered with
// the held output, skipping all arithmetic. A sample that runs a step goes
// through the one-bit-per-cycle divider of the derivative filter, five
// products sequenced through one shared two-stage 33x33 multiplier, and the
// sums and clamps. Only one sample is worked on at a time: the next item is
// taken as soon as a result sits in the output register.
// Reset (arst_n low) restores the register defaults and clears the integrator,
// filter, previous error, previous measurement, held output and update time.
// When res stalls, the finished result waits in the output register, one more
// item may be taken and computed, and its result waits until the register frees.
`default_nettype none

module pid_controller_filtered_derivative_top import pidfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	pidfd_in_if.sink   samp,
	pidfd_out_if.source res,
	pidfd_cfg_if.sink  cfg
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	pidfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samp.valid),
		.in_ready (samp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	pidfd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.target_value   (samp.target_value),
		.measured_value (samp.measured_value),
		.now_ms         (samp.now_ms),
		.cfg_valid      (cfg.valid),
		.cfg_ready      (cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.res_valid      (res.valid),
		.res_ready      (res.ready),
		.drive          (res.drive),
		.updated        (res.updated)
	);

endmodule

`default_nettype wire

[tb/pidfd_drive_check.sv]
// Watches the PID controller's channels, predicts each drive item and compares it with the result.
module pidfd_drive_check import pidfd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	pidfd_in_if   samp,
	pidfd_out_if  res,
	pidfd_cfg_if  cfg,
	output int    pending,
	output int    fails
);

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [DW-1:0] drive;
		logic                 updated;
	} drive_item_t;

	// Expected result items, oldest first.
	drive_item_t drive_q[$];

	// Register copies.
	longint           kp, ki, kd, omin, omax, imin, imax;
	logic [SPW-1:0]   period;

	// Controller state copies.
	longint           integ_sum, filt_d, prev_err, prev_meas, hold_drive;
	logic [DW-1:0]    last_tick;

	int fail_cnt = 0;

	function automatic longint sat32(longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Scaled product, rounded to nearest with ties away from zero, saturated.
	function automatic longint mul_rnd(longint a, longint b, int sh);
		bit              neg;
		longint unsigned p;
		neg = (a < 0) != (b < 0);
		p = mag(a) * mag(b);
		p = (p + (64'd1 << (sh - 1))) >> sh;
		if (p > 64'h8000_0000)
			p = 64'h8000_0000;
		return sat32(neg ? -longint'(p) : longint'(p));
	endfunction

	// Q16.16 quotient with the same rounding; the divisor is positive.
	function automatic longint div_rnd(longint num, longint den);
		bit              neg;
		longint unsigned d, q;
		neg = num < 0;
		d = longint'(den);
		q = ((mag(num) << 16) + d / 2) / d;
		if (q > 64'h8000_0000)
			q = 64'h8000_0000;
		return sat32(neg ? -longint'(q) : longint'(q));
	endfunction

	// One controller step: either the held drive or a fresh PID update.
	function automatic drive_item_t pid_drive(longint tgt, longint meas, logic [DW-1:0] now);
		drive_item_t     r;
		logic [DW-1:0]   elapsed;
		longint          t, err, prop, kth, iterm, integ, a, b, num, den, dterm, y;
		elapsed = now - last_tick;
		t = longint'(period);
		if ((longint'(elapsed) << 16) < t * MS_PER_S) begin
			r.drive = hold_drive[DW-1:0];
			r.updated = 1'b0;
			return r;
		end
		err = sat32(tgt - meas);
		prop = mul_rnd(kp, err, 16);

		// Trapezoidal integrator, max limit tested before min.
		kth = mul_rnd(ki, t, 17);
		iterm = mul_rnd(kth, err + prev_err, 16);
		integ = sat32(integ_sum + iterm);
		if (integ > imax)
			integ = imax;
		else if (integ < imin)
			integ = imin;

		// Band-limited derivative on the measurement.
		a = mul_rnd(kd, meas - prev_meas, 15);
		b = mul_rnd(longint'(TAU2) - t, filt_d, 16);
		num = sat32(a + b);
		den = longint'(TAU2) + t;
		dterm = (den > 0) ? div_rnd(-num, den) : 0;

		y = sat32(prop + integ + dterm);
		if (y > omax)
			y = omax;
		else if (y < omin)
			y = omin;

		integ_sum = integ;
		filt_d = dterm;
		prev_err = err;
		prev_meas = meas;
		hold_drive = y;
		last_tick = now;
		r.drive = y[DW-1:0];
		r.updated = 1'b1;
		return r;
	endfunction

	// Track register writes, check result items, queue predictions.
	always @(posedge clk or negedge arst_n) begin
		drive_item_t exp_item;
		if (!arst_n) begin
			kp = longint'(KP_RESET);
			ki = 0;
			kd = 0;
			period = SPW'(SP_RESET);
			omin = S32_MIN;
			omax = S32_MAX;
			imin = S32_MIN;
			imax = S32_MAX;
			integ_sum = 0;
			filt_d = 0;
			prev_err = 0;
			prev_meas = 0;
			hold_drive = 0;
			last_tick = '0;
			drive_q.delete();
			pending <= 0;
			fails <= fail_cnt;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_KP:   kp = longint'($signed(cfg.data));
					REG_KI:   ki = longint'($signed(cfg.data));
					REG_KD:   kd = longint'($signed(cfg.data));
					REG_SP:   period = cfg.data[SPW-1:0];
					REG_OMIN: omin = longint'($signed(cfg.data));
					REG_OMAX: omax = longint'($signed(cfg.data));
					REG_IMIN: imin = longint'($signed(cfg.data));
					REG_IMAX: imax = longint'($signed(cfg.data));
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (drive_q.size() == 0) begin
					$error("unexpected result item: drive %0d updated %0d",
						res.drive, res.updated);
					fail_cnt++;
				end else begin
					exp_item = drive_q.pop_front();
					if (res.drive !== exp_item.drive) begin
						$error("drive mismatch: expected %0d, actual %0d",
							exp_item.drive, res.drive);
						fail_cnt++;
					end
					if (res.updated !== exp_item.updated) begin
						$error("updated mismatch: expected %0d, actual %0d",
							exp_item.updated, res.updated);
						fail_cnt++;
					end
				end
			end
			if (samp.valid && samp.ready)
				drive_q.push_back(pid_drive(longint'(samp.target_value),
					longint'(samp.measured_value), samp.now_ms));
			pending <= drive_q.size();
			fails <= fail_cnt;
		end
	end

endmodule

[tb/pid_controller_filtered_derivative_top_tb.sv]
// Testbench top for the PID controller: clock, reset, register writes, samples and verdict.
module pid_controller_filtered_derivative_top_tb;
	import pidfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 95;
	localparam logic [DW-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] Q_MIN = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int pending;
	int fails;

	pidfd_in_if  samp_ch ();
	pidfd_out_if res_ch ();
	pidfd_cfg_if cfg_ch ();

	pid_controller_filtered_derivative_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samp   (samp_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	pidfd_drive_check drive_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.samp    (samp_ch),
		.res     (res_ch),
		.cfg     (cfg_ch),
		.pending (pending),
		.fails   (fails)
	);

	always #1 clk = ~clk;

	// Result side stalls at random.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// End the run if no item moves on any channel for too long.
	always @(posedge clk) begin
		if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Q16.16 sample value: mostly small, sometimes an extreme or full range.
	function automatic logic [DW-1:0] rand_q16();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return Q_MAX;
		if (r < 8)
			return Q_MIN;
		if (r < 12)
			return '0;
		if (r < 25)
			return $urandom();
		return $urandom_range(0, 2 * 2**20) - 2**20;
	endfunction

	function automatic logic [DW-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return Q_MAX;
		if (r < 12)
			return Q_MIN;
		if (r < 18)
			return '0;
		if (r < 70)
			return $urandom_range(0, 2 * 2**18) - 2**18;
		return $urandom();
	endfunction

	task automatic cfg_write(cfg_idx_e idx, logic [DW-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// A limit pair: full range, crossed, or a window around zero.
	task automatic write_limits(cfg_idx_e lo_idx, cfg_idx_e hi_idx);
		logic [DW-1:0] lo, hi;
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			lo = Q_MIN;
			hi = Q_MAX;
		end else if (r < 32) begin
			lo = $urandom_range(0, 2**22);
			hi = lo - $urandom_range(1, 2**22);
		end else begin
			lo = 32'd0 - $urandom_range(0, 2**22);
			hi = $urandom_range(0, 2**22);
		end
		cfg_write(lo_idx, lo);
		cfg_write(hi_idx, hi);
	endtask

	// Offer one sample item, after a random gap, and wait until it is taken.
	task automatic send_sample(logic [DW-1:0] tgt, logic [DW-1:0] meas, logic [DW-1:0] now);
		if ($urandom_range(0, 99) < idle_pct) begin
			samp_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(posedge clk);
		end
		samp_ch.valid <= 1'b1;
		samp_ch.target_value <= tgt;
		samp_ch.measured_value <= meas;
		samp_ch.now_ms <= now;
		@(posedge clk);
		while (!samp_ch.ready)
			@(posedge clk);
	endtask

	// Hold off the sender until every expected item has come back.
	task automatic wait_idle();
		samp_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [DW-1:0]  tick, tgt, meas;
		logic [SPW-1:0] cur_period;
		longint         thr;
		int             r;

		samp_ch.valid <= 1'b0;
		samp_ch.target_value <= '0;
		samp_ch.measured_value <= '0;
		samp_ch.now_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_KP;
		cfg_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a 10 ms gate, saturating errors and a wrapped tick.
		send_sample('0, '0, '0);
		send_sample(Q_MAX, Q_MIN, 32'd10);
		send_sample(Q_MIN, Q_MAX, 32'd19);
		send_sample(Q_MIN, Q_MAX, 32'd20);
		send_sample(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
		wait_idle();

		// Extreme gains, zero period so the gate never holds, crossed limits.
		cfg_write(REG_KP, Q_MAX);
		cfg_write(REG_KI, Q_MIN);
		cfg_write(REG_KD, Q_MAX);
		cfg_write(REG_SP, '0);
		cfg_write(REG_OMIN, 32'sd100);
		cfg_write(REG_OMAX, -32'sd100);
		cfg_write(REG_IMIN, 32'sd5000);
		cfg_write(REG_IMAX, -32'sd5000);
		send_sample(Q_MAX, Q_MIN, 32'hFFFF_FFFF);
		send_sample('0, '0, 32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFF, 32'd1, '0);
		send_sample(Q_MIN, Q_MAX, '0);
		wait_idle();

		// Opposite extreme gains and the largest nominal period of ten seconds.
		cfg_write(REG_KP, Q_MIN);
		cfg_write(REG_KI, Q_MAX);
		cfg_write(REG_KD, Q_MIN);
		cfg_write(REG_SP, 20'hA0000);
		cfg_write(REG_OMIN, Q_MIN);
		cfg_write(REG_OMAX, Q_MAX);
		cfg_write(REG_IMIN, -32'sd1048576);
		cfg_write(REG_IMAX, 32'sd1048576);
		send_sample(Q_MAX, '0, 32'd10000);
		send_sample('0, Q_MAX, 32'd19999);
		send_sample('0, Q_MIN, 32'd20000);
		send_sample(32'd12345, -32'sd54321, 32'd30000);
		send_sample(Q_MIN, Q_MIN, 32'd40000);
		wait_idle();

		// Unit gains and the widest period field.
		cfg_write(REG_KP, 32'h0001_0000);
		cfg_write(REG_KI, 32'h0001_0000);
		cfg_write(REG_KD, 32'h0001_0000);
		cfg_write(REG_SP, 20'hFFFFF);
		send_sample(32'h0002_0000, 32'h0001_8000, 32'd56000);
		send_sample(32'h0002_0000, 32'h0001_0000, 32'd71999);
		send_sample(32'hFFFE_0000, 32'h0003_0000, 32'd72000);
		tick = 32'd72000;

		// Random phases: new settings each time, idling pattern rotates.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			cfg_write(REG_KP, pick_gain());
			cfg_write(REG_KI, pick_gain());
			cfg_write(REG_KD, pick_gain());
			r = $urandom_range(0, 99);
			if (r < 10)
				cur_period = '0;
			else if (r < 17)
				cur_period = 20'hA0000;
			else if (r < 22)
				cur_period = '1;
			else if (r < 30)
				cur_period = 20'd1;
			else
				cur_period = SPW'($urandom_range(1, 6554));
			cfg_write(REG_SP, {12'($urandom()), cur_period});
			write_limits(REG_IMIN, REG_IMAX);
			write_limits(REG_OMIN, REG_OMAX);
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 65;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 65;
				end
				default: begin
					idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			thr = (longint'(cur_period) * MS_PER_S + 65535) / 65536;

			// Ticks land short of, on and past the gate, with an odd jump.
			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 30)
					tick += (thr > 0) ? $urandom_range(0, int'(thr) - 1) : 0;
				else if (r < 40)
					tick += (thr > 0) ? DW'(thr - 1) : '0;
				else if (r < 55)
					tick += DW'(thr);
				else if (r < 92)
					tick += DW'(thr) + $urandom_range(0, int'(thr) + 5);
				else
					tick = $urandom();
				tgt = rand_q16();
				if ($urandom_range(0, 1) == 0)
					meas = tgt + ($urandom_range(0, 2 * 2**16) - 2**16);
				else
					meas = rand_q16();
				send_sample(tgt, meas, tick);
			end
		end

		wait_idle();
		if (fails == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
